// File: rtl/core/dscs_pkg.sv
// Shared types, constants and the control program of the click synthesiser.
`default_nettype none

package dscs_pkg;

    // Default parameter values for the top level.
    localparam int DEF_SAMPLE_WIDTH     = 16;
    localparam int DEF_PHASE_WIDTH      = 32;
    localparam int DEF_SINE_TABLE_DEPTH = 1024;

    // Quarter turn in Q30, used to build the sine table.
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Configuration port geometry and register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_AMPLITUDE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLICK_LENGTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DOWNBEAT_STEP = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFBEAT_STEP  = 3'd4;

    // Register values after reset.
    localparam logic [14:0] RST_AMPLITUDE     = 15'd32767;
    localparam logic [15:0] RST_CLICK_LENGTH  = 16'd1440;
    localparam logic [31:0] RST_DOWNBEAT_STEP = 32'd143165577;
    localparam logic [31:0] RST_OFFBEAT_STEP  = 32'd89478485;

    // Trigger codes.
    localparam logic [1:0] TRIG_OFFBEAT  = 2'd1;
    localparam logic [1:0] TRIG_DOWNBEAT = 2'd2;

    // Configuration register bank as seen by the datapath.
    typedef struct packed {
        logic        enable;
        logic [14:0] amplitude;
        logic [15:0] click_length;
        logic [31:0] downbeat_step;
        logic [31:0] offbeat_step;
    } t_cfg;

    // Datapath operations, one per control word.
    typedef enum logic [3:0] {
        OP_LOAD,
        OP_TRIG,
        OP_CHK,
        OP_MIDX,
        OP_NOP,
        OP_MAMP,
        OP_MLEFT,
        OP_DIVINIT,
        OP_DIVSTEP,
        OP_ACC,
        OP_OUT
    } t_op;

    // Jump conditions.
    typedef enum logic [2:0] {
        C_NEVER,
        C_NOITEM,
        C_NOCLICK,
        C_DIVMORE,
        C_OUTBUSY
    } t_cond;

    // Program addresses.
    typedef enum logic [3:0] {
        A_IDLE,
        A_TRIG,
        A_CHK,
        A_IDX,
        A_ROM,
        A_MAMP,
        A_MLEFT,
        A_DIVI,
        A_DIV,
        A_ACC,
        A_OUT
    } t_addr;

    // One control word: operation, jump condition, jump target and fall-through.
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_addr target;
        t_addr next;
    } t_uword;

    // Status flags fed back from the datapath to the sequencer.
    typedef struct packed {
        logic item_valid;
        logic no_click;
        logic div_more;
        logic out_busy;
    } t_status;

    // The control program.
    function automatic t_uword ucode(input t_addr addr);
        t_uword w;
        case (addr)
            A_IDLE:  w = '{op: OP_LOAD,    cond: C_NOITEM,  target: A_IDLE, next: A_TRIG};
            A_TRIG:  w = '{op: OP_TRIG,    cond: C_NEVER,   target: A_IDLE, next: A_CHK};
            A_CHK:   w = '{op: OP_CHK,     cond: C_NOCLICK, target: A_OUT,  next: A_IDX};
            A_IDX:   w = '{op: OP_MIDX,    cond: C_NEVER,   target: A_IDLE, next: A_ROM};
            A_ROM:   w = '{op: OP_NOP,     cond: C_NEVER,   target: A_IDLE, next: A_MAMP};
            A_MAMP:  w = '{op: OP_MAMP,    cond: C_NEVER,   target: A_IDLE, next: A_MLEFT};
            A_MLEFT: w = '{op: OP_MLEFT,   cond: C_NEVER,   target: A_IDLE, next: A_DIVI};
            A_DIVI:  w = '{op: OP_DIVINIT, cond: C_NEVER,   target: A_IDLE, next: A_DIV};
            A_DIV:   w = '{op: OP_DIVSTEP, cond: C_DIVMORE, target: A_DIV,  next: A_ACC};
            A_ACC:   w = '{op: OP_ACC,     cond: C_NEVER,   target: A_IDLE, next: A_OUT};
            A_OUT:   w = '{op: OP_OUT,     cond: C_OUTBUSY, target: A_OUT,  next: A_IDLE};
            default: w = '{op: OP_NOP,     cond: C_NEVER,   target: A_IDLE, next: A_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/dscs_cfg.sv
// Configuration register bank of the click synthesiser.
`default_nettype none

module dscs_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [dscs_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [dscs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output dscs_pkg::t_cfg                           o_cfg
);

    dscs_pkg::t_cfg r_cfg;

    // Writes are always taken.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register writes; an index beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable        <= 1'b0;
            r_cfg.amplitude     <= dscs_pkg::RST_AMPLITUDE;
            r_cfg.click_length  <= dscs_pkg::RST_CLICK_LENGTH;
            r_cfg.downbeat_step <= dscs_pkg::RST_DOWNBEAT_STEP;
            r_cfg.offbeat_step  <= dscs_pkg::RST_OFFBEAT_STEP;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dscs_pkg::CFG_ENABLE:        r_cfg.enable        <= i_cfg_data[0];
                dscs_pkg::CFG_AMPLITUDE:     r_cfg.amplitude     <= i_cfg_data[14:0];
                dscs_pkg::CFG_CLICK_LENGTH:  r_cfg.click_length  <= i_cfg_data[15:0];
                dscs_pkg::CFG_DOWNBEAT_STEP: r_cfg.downbeat_step <= i_cfg_data[31:0];
                dscs_pkg::CFG_OFFBEAT_STEP:  r_cfg.offbeat_step  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/dscs_sine_rom.sv
// Quarter-wave sine table with a registered read port.
`default_nettype none

module dscs_sine_rom #(
    parameter int SINE_TABLE_DEPTH = dscs_pkg::DEF_SINE_TABLE_DEPTH,
    parameter int ADDR_W           = $clog2(SINE_TABLE_DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic [ADDR_W-1:0] i_addr,
    output logic      [14:0]       o_sine
);

    // Entry i is sin(i * pi / (2 * depth)) in Q15, from a Q30 Taylor series to x^15.
    function automatic logic [SINE_TABLE_DEPTH:0][14:0] build_table();
        logic [SINE_TABLE_DEPTH:0][14:0] tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          r;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            x    = (longint'(i) * dscs_pkg::HALF_PI_Q30) / SINE_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 7; k++) begin
                term = (term * x2) >> 30;
                case (k)
                    1:       term = term / 6;
                    2:       term = term / 20;
                    3:       term = term / 42;
                    4:       term = term / 72;
                    5:       term = term / 110;
                    6:       term = term / 156;
                    default: term = term / 210;
                endcase
                if ((k & 1) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            r = (sum + 16384) >>> 15;
            if (r > 32767) begin
                r = 32767;
            end
            tab[i] = 15'(r);
        end
        return tab;
    endfunction

    localparam logic [SINE_TABLE_DEPTH:0][14:0] SINE_TAB = build_table();

    // Registered read.
    always_ff @(posedge i_clk) begin
        o_sine <= SINE_TAB[i_addr];
    end

endmodule

`default_nettype wire

// File: rtl/core/dscs_seq.sv
// Microcode sequencer: step counter, program table and conditional jumps.
`default_nettype none

module dscs_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  dscs_pkg::t_status      i_status,
    output dscs_pkg::t_op          o_op
);

    dscs_pkg::t_addr  r_step;
    dscs_pkg::t_addr  n_step;
    dscs_pkg::t_uword w_word;
    logic             w_jump;

    // Fetch the control word and resolve its jump condition.
    always_comb begin
        w_word = dscs_pkg::ucode(r_step);
        case (w_word.cond)
            dscs_pkg::C_NOITEM:  w_jump = !i_status.item_valid;
            dscs_pkg::C_NOCLICK: w_jump = i_status.no_click;
            dscs_pkg::C_DIVMORE: w_jump = i_status.div_more;
            dscs_pkg::C_OUTBUSY: w_jump = i_status.out_busy;
            default:             w_jump = 1'b0;
        endcase
        n_step = w_jump ? w_word.target : w_word.next;
    end

    assign o_op = w_word.op;

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= dscs_pkg::A_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/dscs_datapath.sv
// Datapath: click state, shared multiplier, serial divider, mixer and output register.
`default_nettype none

module dscs_datapath #(
    parameter int SAMPLE_WIDTH     = dscs_pkg::DEF_SAMPLE_WIDTH,
    parameter int PHASE_WIDTH      = dscs_pkg::DEF_PHASE_WIDTH,
    parameter int SINE_TABLE_DEPTH = dscs_pkg::DEF_SINE_TABLE_DEPTH,
    parameter int ADDR_W           = $clog2(SINE_TABLE_DEPTH + 1)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  dscs_pkg::t_op                       i_op,
    input  dscs_pkg::t_cfg                      i_cfg,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_in_sample,
    input  wire logic        [1:0]              i_trigger,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic signed      [SAMPLE_WIDTH-1:0] o_out_sample,
    output logic                                o_click_start,
    output logic             [ADDR_W-1:0]       o_rom_addr,
    input  wire logic        [14:0]             i_rom_data,
    output dscs_pkg::t_status                   o_status
);

    localparam int QB    = PHASE_WIDTH - 2;
    localparam int MAW   = (QB > 30) ? QB : 30;
    localparam int PRW   = MAW + 16;
    localparam int QW    = 31;
    localparam int SH_UP = (SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH - 16 : 0;
    localparam int SH_DN = (SAMPLE_WIDTH < 16) ? 16 - SAMPLE_WIDTH : 0;
    localparam int CMW   = QW + SH_UP;
    localparam int AW    = CMW + 2;

    localparam logic signed [AW-1:0] SMAX = {{(AW - SAMPLE_WIDTH + 1){1'b0}},
                                             {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [AW-1:0] SMIN = ~SMAX;

    // Click state.
    logic [PHASE_WIDTH-1:0] r_phase;
    logic [PHASE_WIDTH-1:0] r_phase_step;
    logic [15:0]            r_left;

    // Item and working registers.
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic        [1:0]              r_trig;
    logic                           r_started;
    logic        [PRW-1:0]          r_prod;
    logic        [QW-1:0]           r_quo;
    logic        [15:0]             r_rem;
    logic        [4:0]              r_cnt;
    logic signed [AW-1:0]           r_acc;

    logic [MAW-1:0]          w_mul_a;
    logic [15:0]             w_mul_b;
    logic [PRW-1:0]          w_prod;
    logic [15:0]             w_divisor;
    logic [16:0]             w_shifted;
    logic [16:0]             w_diff;
    logic [CMW-1:0]          w_mag;
    logic signed [AW-1:0]    w_sext;
    logic signed [AW-1:0]    w_click;
    logic signed [AW-1:0]    w_sat;
    logic [ADDR_W-1:0]       w_k;
    logic                    w_out_busy;

    // Shared multiplier operand selection.
    always_comb begin
        case (i_op)
            dscs_pkg::OP_MIDX: begin
                w_mul_a = MAW'(r_phase[QB-1:0]);
                w_mul_b = 16'(SINE_TABLE_DEPTH);
            end
            dscs_pkg::OP_MAMP: begin
                w_mul_a = MAW'(i_cfg.amplitude);
                w_mul_b = {1'b0, i_rom_data};
            end
            default: begin
                w_mul_a = MAW'(r_prod[29:0]);
                w_mul_b = r_left;
            end
        endcase
        w_prod = PRW'(w_mul_a) * PRW'(w_mul_b);
    end

    // Table address: the index is mirrored in the odd quadrants.
    assign w_k        = r_prod[QB +: ADDR_W];
    assign o_rom_addr = r_phase[PHASE_WIDTH-2] ? (ADDR_W'(SINE_TABLE_DEPTH) - w_k) : w_k;

    // One step of the restoring divider; a zero click length divides by one.
    assign w_divisor = (i_cfg.click_length == 16'd0) ? 16'd1 : i_cfg.click_length;
    assign w_shifted = {r_rem, r_quo[QW-1]};
    assign w_diff    = w_shifted - {1'b0, w_divisor};

    // Scale the quotient to the sample width, apply the sine sign and saturate.
    assign w_mag   = (CMW'(r_quo) << SH_UP) >> SH_DN;
    assign w_sext  = {{(AW - SAMPLE_WIDTH){r_sample[SAMPLE_WIDTH-1]}}, r_sample};
    assign w_click = r_phase[PHASE_WIDTH-1] ? -$signed({2'b00, w_mag})
                                            :  $signed({2'b00, w_mag});
    always_comb begin
        if (r_acc > SMAX) begin
            w_sat = SMAX;
        end else if (r_acc < SMIN) begin
            w_sat = SMIN;
        end else begin
            w_sat = r_acc;
        end
    end

    // Handshake and status back to the sequencer.
    assign w_out_busy          = o_out_valid && !i_out_ready;
    assign o_in_ready          = (i_op == dscs_pkg::OP_LOAD);
    assign o_status.item_valid = i_in_valid;
    assign o_status.no_click   = !i_cfg.enable || (r_left == 16'd0);
    assign o_status.div_more   = (r_cnt != 5'd0);
    assign o_status.out_busy   = w_out_busy;

    // Click state and output valid, both under reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= '0;
            r_phase_step <= '0;
            r_left       <= '0;
            o_out_valid  <= 1'b0;
        end else begin
            if (i_op == dscs_pkg::OP_TRIG && i_cfg.enable &&
                (r_trig == dscs_pkg::TRIG_OFFBEAT || r_trig == dscs_pkg::TRIG_DOWNBEAT)) begin
                r_phase      <= '0;
                r_left       <= i_cfg.click_length;
                r_phase_step <= (r_trig == dscs_pkg::TRIG_DOWNBEAT)
                                ? PHASE_WIDTH'(i_cfg.downbeat_step)
                                : PHASE_WIDTH'(i_cfg.offbeat_step);
            end else if (i_op == dscs_pkg::OP_ACC) begin
                r_phase <= r_phase + r_phase_step;
                r_left  <= r_left - 16'd1;
            end
            if (i_op == dscs_pkg::OP_OUT && !w_out_busy) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Working registers, stepped by the current operation.
    always_ff @(posedge i_clk) begin
        case (i_op)
            dscs_pkg::OP_LOAD: begin
                if (i_in_valid) begin
                    r_sample <= i_in_sample;
                    r_trig   <= i_trigger;
                end
            end
            dscs_pkg::OP_TRIG: begin
                r_started <= i_cfg.enable &&
                             (r_trig == dscs_pkg::TRIG_OFFBEAT ||
                              r_trig == dscs_pkg::TRIG_DOWNBEAT);
            end
            dscs_pkg::OP_CHK: begin
                r_acc <= w_sext;
            end
            dscs_pkg::OP_MIDX, dscs_pkg::OP_MAMP, dscs_pkg::OP_MLEFT: begin
                r_prod <= w_prod;
            end
            dscs_pkg::OP_DIVINIT: begin
                r_quo <= r_prod[15 +: QW];
                r_rem <= '0;
                r_cnt <= 5'(QW - 1);
            end
            dscs_pkg::OP_DIVSTEP: begin
                if (!w_diff[16]) begin
                    r_rem <= w_diff[15:0];
                    r_quo <= {r_quo[QW-2:0], 1'b1};
                end else begin
                    r_rem <= w_shifted[15:0];
                    r_quo <= {r_quo[QW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
            end
            dscs_pkg::OP_ACC: begin
                r_acc <= w_sext + w_click;
            end
            dscs_pkg::OP_OUT: begin
                if (!w_out_busy) begin
                    o_out_sample  <= w_sat[SAMPLE_WIDTH-1:0];
                    o_click_start <= r_started;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/decaying_sine_click_synth.sv
// An item with no click running goes through the load, trigger, check and output steps;
// with a click it also takes the table index and read, the amplitude and decay products,
// the 31-step restoring divider and the mix. No new item is taken until the current one
// leaves its output step, but the next item is taken while a result waits.
// Reset (synchronous, active low) returns registers to their defaults, clears the
// click state and the output valid, and puts the sequencer at its idle step.
`default_nettype none

module decaying_sine_click_synth #(
    parameter int SAMPLE_WIDTH     = dscs_pkg::DEF_SAMPLE_WIDTH,
    parameter int PHASE_WIDTH      = dscs_pkg::DEF_PHASE_WIDTH,
    parameter int SINE_TABLE_DEPTH = dscs_pkg::DEF_SINE_TABLE_DEPTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [dscs_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [dscs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]      i_in_sample,
    input  wire logic        [1:0]                   i_trigger,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed      [SAMPLE_WIDTH-1:0]      o_out_sample,
    output logic                                     o_click_start
);

    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);

    dscs_pkg::t_cfg    w_cfg;
    dscs_pkg::t_op     w_op;
    dscs_pkg::t_status w_status;
    logic [ADDR_W-1:0] w_rom_addr;
    logic [14:0]       w_rom_data;

    // Configuration registers.
    dscs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Control program sequencer.
    dscs_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_op     (w_op)
    );

    // Sine table.
    dscs_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .ADDR_W           (ADDR_W)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_sine (w_rom_data)
    );

    // Arithmetic and item handling.
    dscs_datapath #(
        .SAMPLE_WIDTH     (SAMPLE_WIDTH),
        .PHASE_WIDTH      (PHASE_WIDTH),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .ADDR_W           (ADDR_W)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (w_op),
        .i_cfg         (w_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_sample   (i_in_sample),
        .i_trigger     (i_trigger),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_sample  (o_out_sample),
        .o_click_start (o_click_start),
        .o_rom_addr    (w_rom_addr),
        .i_rom_data    (w_rom_data),
        .o_status      (w_status)
    );

endmodule

`default_nettype wire

// File: bench/decaying_sine_click_synth_tb.sv
// Self-checking testbench of the decaying-sine click synthesiser, with its own click predictor.
`timescale 1ns / 1ps

module decaying_sine_click_synth_tb;

    localparam int SW             = dscs_pkg::DEF_SAMPLE_WIDTH;
    localparam int TABLE_D        = dscs_pkg::DEF_SINE_TABLE_DEPTH;
    localparam int RANDOM_ITEMS   = 1900;
    localparam int HOLD_CYCLES    = 400;
    localparam int QUIET_LO       = 900;
    localparam int QUIET_HI       = 1200;
    localparam int TAIL_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef longint unsigned u64_t;

    typedef enum {PEND_SAMPLE, PEND_WRITE, PEND_DRAIN} pend_kind_t;

    typedef struct {
        pend_kind_t      kind;
        logic [SW-1:0]   pcm;
        logic [1:0]      trig;
        logic [dscs_pkg::CFG_INDEX_W-1:0] index;
        logic [dscs_pkg::CFG_DATA_W-1:0]  data;
    } pend_t;

    typedef struct {
        logic signed [SW-1:0] pcm;
        logic                 start;
    } click_res_t;

    // Ports of the block.
    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  i_cfg_valid = 1'b0;
    logic                                  o_cfg_ready;
    logic [dscs_pkg::CFG_INDEX_W-1:0]      i_cfg_index = '0;
    logic [dscs_pkg::CFG_DATA_W-1:0]       i_cfg_data = '0;
    logic                                  i_in_valid = 1'b0;
    logic                                  o_in_ready;
    logic signed [SW-1:0]                  i_in_sample = '0;
    logic [1:0]                            i_trigger = '0;
    logic                                  o_out_valid;
    logic                                  i_out_ready = 1'b0;
    logic signed [SW-1:0]                  o_out_sample;
    logic                                  o_click_start;

    // Stimulus and expectation stores.
    pend_t      pending_q[$];
    click_res_t expected_q[$];

    // Predictor copy of the registers and the click state.
    logic        cfg_enable;
    logic [14:0] cfg_amp;
    logic [15:0] cfg_len;
    logic [31:0] cfg_down;
    logic [31:0] cfg_off;
    logic [31:0] click_phase;
    logic [31:0] click_step;
    logic [15:0] click_left;
    int          sine_tab [0:TABLE_D];

    // Handshake bookkeeping shared by the driver, the receiver, the monitor and the stimulus.
    bit in_busy, in_taken, cfg_busy, cfg_taken;
    bit hold_done;
    int hold_left, hold_at;
    int n_in_acc, n_out, n_starts, n_writes, n_errors, n_settings, quiet_cycles;

    decaying_sine_click_synth u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_sample   (i_in_sample),
        .i_trigger     (i_trigger),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_sample  (o_out_sample),
        .o_click_start (o_click_start)
    );

    // Clock generation.
    always #6 i_clk = ~i_clk;

    // Signed sine value of a phase, from the quarter-wave table.
    function automatic int sine_at(input logic [31:0] ph);
        u64_t k;
        int   v;
        k = (u64_t'(ph[29:0]) * TABLE_D) >> 30;
        if (k > TABLE_D) k = TABLE_D;
        v = ph[30] ? sine_tab[TABLE_D - k] : sine_tab[k];
        return ph[31] ? -v : v;
    endfunction

    // Works out the output of one accepted sample and advances the click state.
    task automatic predict_click(input logic signed [SW-1:0] pcm, input logic [1:0] trig,
                                 output click_res_t res);
        longint acc, len, num, c;
        acc = pcm;
        res.start = 1'b0;
        if (cfg_enable) begin
            if (trig == dscs_pkg::TRIG_OFFBEAT || trig == dscs_pkg::TRIG_DOWNBEAT) begin
                click_phase = '0;
                click_left  = cfg_len;
                click_step  = (trig == dscs_pkg::TRIG_DOWNBEAT) ? cfg_down : cfg_off;
                res.start   = 1'b1;
            end
            if (click_left != 0) begin
                len = (cfg_len == 0) ? 1 : longint'(cfg_len);
                num = longint'(cfg_amp) * longint'(sine_at(click_phase)) * longint'(click_left);
                c   = num / (len * 32768);
                acc = acc + c;
                click_phase = click_phase + click_step;
                click_left  = click_left - 16'd1;
            end
        end
        if (acc > longint'(2 ** (SW - 1) - 1)) acc = 2 ** (SW - 1) - 1;
        if (acc < -longint'(2 ** (SW - 1)))    acc = -(2 ** (SW - 1));
        res.pcm = acc[SW-1:0];
    endtask

    // Register write as seen by the predictor; unused indexes are ignored.
    task automatic apply_write(input logic [dscs_pkg::CFG_INDEX_W-1:0] index,
                               input logic [dscs_pkg::CFG_DATA_W-1:0] data);
        case (index)
            dscs_pkg::CFG_ENABLE:        cfg_enable = data[0];
            dscs_pkg::CFG_AMPLITUDE:     cfg_amp    = data[14:0];
            dscs_pkg::CFG_CLICK_LENGTH:  cfg_len    = data[15:0];
            dscs_pkg::CFG_DOWNBEAT_STEP: cfg_down   = data;
            dscs_pkg::CFG_OFFBEAT_STEP:  cfg_off    = data;
            default: ;
        endcase
    endtask

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at result %0d: %s", n_out, msg);
        n_errors++;
    endtask

    task automatic queue_sample(input logic [SW-1:0] pcm, input logic [1:0] trig);
        pend_t p;
        p.kind = PEND_SAMPLE;
        p.pcm = pcm;
        p.trig = trig;
        p.index = '0;
        p.data = '0;
        pending_q.push_back(p);
    endtask

    task automatic queue_write(input logic [dscs_pkg::CFG_INDEX_W-1:0] index,
                               input logic [dscs_pkg::CFG_DATA_W-1:0] data);
        pend_t p;
        p.kind = PEND_WRITE;
        p.pcm = '0;
        p.trig = '0;
        p.index = index;
        p.data = data;
        pending_q.push_back(p);
    endtask

    task automatic queue_drain();
        pend_t p;
        p.kind = PEND_DRAIN;
        p.pcm = '0;
        p.trig = '0;
        p.index = '0;
        p.data = '0;
        pending_q.push_back(p);
    endtask

    // Sender: issues items and register writes at the falling edge.
    always @(negedge i_clk) begin : driver
        pend_t cur;
        if (in_taken) begin
            in_busy  = 1'b0;
            in_taken = 1'b0;
        end
        if (cfg_taken) begin
            cfg_busy  = 1'b0;
            cfg_taken = 1'b0;
        end
        if (i_rst_n && !in_busy && !cfg_busy && pending_q.size() > 0) begin
            cur = pending_q[0];
            case (cur.kind)
                PEND_SAMPLE: begin
                    if ((n_in_acc >= QUIET_LO && n_in_acc < QUIET_HI) ||
                        $urandom_range(99) >= 13) begin
                        void'(pending_q.pop_front());
                        i_in_sample <= cur.pcm;
                        i_trigger   <= cur.trig;
                        in_busy = 1'b1;
                    end
                end
                PEND_WRITE: begin
                    // Registers change only once every result is back.
                    if (expected_q.size() == 0) begin
                        void'(pending_q.pop_front());
                        i_cfg_index <= cur.index;
                        i_cfg_data  <= cur.data;
                        cfg_busy = 1'b1;
                    end
                end
                default: begin
                    if (expected_q.size() == 0) void'(pending_q.pop_front());
                end
            endcase
        end
        i_in_valid  <= in_busy;
        i_cfg_valid <= cfg_busy;
    end

    // Receiver: random back-pressure, one long hold-off, and a stretch without stalls.
    always @(negedge i_clk) begin
        if (!hold_done && n_in_acc >= hold_at) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (n_out >= QUIET_LO && n_out < QUIET_HI) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= 13);
        end
    end

    // Monitor: records accepted items and writes, and checks every result.
    always @(posedge i_clk) begin : monitor
        click_res_t want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                n_out++;
                if (expected_q.size() == 0) begin
                    flag_mismatch("result with no sample waiting");
                end else begin
                    want = expected_q.pop_front();
                    if (o_out_sample !== want.pcm)
                        flag_mismatch($sformatf("out_sample %0d, predicted %0d",
                                                o_out_sample, want.pcm));
                    if (o_click_start !== want.start)
                        flag_mismatch($sformatf("click_start %0b, predicted %0b",
                                                o_click_start, want.start));
                end
            end
            if (i_in_valid && o_in_ready) begin
                predict_click(i_in_sample, i_trigger, want);
                expected_q.push_back(want);
                if (want.start) n_starts++;
                n_in_acc++;
                in_taken = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                apply_write(i_cfg_index, i_cfg_data);
                n_writes++;
                cfg_taken = 1'b1;
            end
        end
    end

    // Watchdog on cycles in which no channel moves anything.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (i_cfg_valid && o_cfg_ready) ||
            (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin : stimulus
        u64_t        x, x2, term;
        longint      sum, r;
        int          n_random, n_items, len_mid, trig_pct, pick;
        logic [31:0] upper, val;
        logic [1:0]  trig;
        logic [SW-1:0] pcm;

        // Quarter-wave table, Q30 Taylor series up to the fifteenth power.
        for (int i = 0; i <= TABLE_D; i++) begin
            x    = (u64_t'(i) * dscs_pkg::HALF_PI_Q30) / TABLE_D;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 7; k++) begin
                term = ((term * x2) >> 30) / u64_t'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) sum = sum - longint'(term);
                else            sum = sum + longint'(term);
            end
            if (sum < 0) sum = 0;
            r = (sum + 16384) >>> 15;
            if (r > 32767) r = 32767;
            sine_tab[i] = int'(r);
        end

        // Predictor state after reset.
        cfg_enable  = 1'b0;
        cfg_amp     = dscs_pkg::RST_AMPLITUDE;
        cfg_len     = dscs_pkg::RST_CLICK_LENGTH;
        cfg_down    = dscs_pkg::RST_DOWNBEAT_STEP;
        cfg_off     = dscs_pkg::RST_OFFBEAT_STEP;
        click_phase = '0;
        click_step  = '0;
        click_left  = '0;

        // Disabled: triggers are ignored and samples pass through.
        queue_sample(16'h7FFF, dscs_pkg::TRIG_DOWNBEAT);
        queue_sample(16'h8000, dscs_pkg::TRIG_OFFBEAT);
        queue_sample(16'h1234, 2'd3);

        // Quarter-turn steps walk all four quadrants and saturate both ways.
        queue_write(dscs_pkg::CFG_ENABLE, 32'd1);
        queue_write(dscs_pkg::CFG_AMPLITUDE, 32'h7FFF);
        queue_write(dscs_pkg::CFG_CLICK_LENGTH, 32'd4);
        queue_write(dscs_pkg::CFG_DOWNBEAT_STEP, 32'h4000_0000);
        queue_write(dscs_pkg::CFG_OFFBEAT_STEP, 32'hC000_0000);
        n_settings = 2;
        queue_sample(16'h0000, dscs_pkg::TRIG_DOWNBEAT);
        queue_sample(16'h7FFF, 2'd0);
        queue_sample(16'h8000, 2'd3);
        queue_sample(16'h8000, 2'd0);
        queue_sample(16'h0100, 2'd0);

        // A new trigger restarts a running click.
        queue_sample(16'h0000, dscs_pkg::TRIG_OFFBEAT);
        queue_sample(16'h0000, 2'd0);
        queue_sample(16'h0000, dscs_pkg::TRIG_DOWNBEAT);
        queue_sample(16'h0000, 2'd0);

        // Zero click length flags the start but adds nothing.
        queue_write(dscs_pkg::CFG_CLICK_LENGTH, 32'd0);
        n_settings++;
        queue_sample(16'h0100, dscs_pkg::TRIG_OFFBEAT);
        queue_sample(16'h0100, 2'd0);

        // Shortening the click while it runs pushes the decay factor past one.
        queue_write(dscs_pkg::CFG_CLICK_LENGTH, 32'd1000);
        queue_write(dscs_pkg::CFG_DOWNBEAT_STEP, 32'h0147_AE14);
        queue_sample(16'h0000, dscs_pkg::TRIG_DOWNBEAT);
        queue_sample(16'h0000, 2'd0);
        queue_sample(16'h0000, 2'd0);
        queue_sample(16'h0000, 2'd0);
        queue_drain();
        queue_write(dscs_pkg::CFG_CLICK_LENGTH, 32'd1);
        n_settings += 2;
        queue_sample(16'h0000, 2'd0);
        queue_sample(16'h0000, 2'd0);
        queue_sample(16'h0000, 2'd0);

        // Silent click and the largest step.
        queue_write(dscs_pkg::CFG_AMPLITUDE, 32'd0);
        queue_write(dscs_pkg::CFG_DOWNBEAT_STEP, 32'hFFFF_FFFF);
        n_settings++;
        queue_sample(16'h5555, dscs_pkg::TRIG_DOWNBEAT);
        queue_sample(16'hAAAA, 2'd0);

        // The long receiver hold-off falls early in the first random phase.
        hold_at = 23 + 20;

        // Random phases: a fresh setting, then clicks with random content.
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            upper = ($urandom_range(3) == 0) ? ($urandom & 32'hFFFF_0000) : 32'h0;
            queue_write(dscs_pkg::CFG_ENABLE,
                        upper | (($urandom_range(9) == 0) ? 32'd0 : 32'd1));
            case ($urandom_range(7))
                0:       val = 32'd0;
                1:       val = 32'h7FFF;
                default: val = $urandom_range(32767);
            endcase
            queue_write(dscs_pkg::CFG_AMPLITUDE, upper | val);
            case ($urandom_range(9))
                0:       val = 32'd0;
                1:       val = 32'd65535;
                2:       val = 32'd1440;
                3:       val = 32'd1;
                default: val = $urandom_range(300, 2);
            endcase
            queue_write(dscs_pkg::CFG_CLICK_LENGTH, upper | val);
            for (int s = 0; s < 2; s++) begin
                case ($urandom_range(7))
                    0:       val = 32'd0;
                    1:       val = 32'hFFFF_FFFF;
                    2:       val = 32'h4000_0000;
                    default: val = $urandom;
                endcase
                queue_write(s == 0 ? dscs_pkg::CFG_DOWNBEAT_STEP : dscs_pkg::CFG_OFFBEAT_STEP,
                            val);
            end
            // Writes to unused indexes must leave everything alone.
            if ($urandom_range(3) == 0)
                queue_write(3'(5 + $urandom_range(2)), $urandom);
            n_settings++;

            n_items  = (n_random == 0) ? 250 : $urandom_range(200, 60);
            len_mid  = ($urandom_range(9) < 3) ? n_items / 2 : -1;
            case ($urandom_range(2))
                0:       trig_pct = 2;
                1:       trig_pct = 6;
                default: trig_pct = 15;
            endcase
            for (int j = 0; j < n_items; j++) begin
                if (j == len_mid) begin
                    queue_write(dscs_pkg::CFG_CLICK_LENGTH, $urandom_range(40, 1));
                    n_settings++;
                end
                case ($urandom_range(15))
                    0:       pcm = 16'h7FFF;
                    1:       pcm = 16'h8000;
                    2:       pcm = 16'h0000;
                    default: pcm = $urandom;
                endcase
                pick = $urandom_range(99);
                if (pick < trig_pct)              trig = dscs_pkg::TRIG_OFFBEAT;
                else if (pick < 2 * trig_pct)     trig = dscs_pkg::TRIG_DOWNBEAT;
                else if (pick < 2 * trig_pct + 3) trig = 2'd3;
                else                              trig = 2'd0;
                queue_sample(pcm, trig);
            end
            n_random += n_items;
            // Now and then the sender waits for every result before going on.
            if ($urandom_range(3) == 0) queue_drain();
        end

        // Reset once, released on a falling edge.
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || in_busy || cfg_busy || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d samples and %0d results, %0d of them starting a click,",
                 n_in_acc, n_out, n_starts);
        $display("with %0d register writes across %0d settings; %0d mismatches.",
                 n_writes, n_settings, n_errors);
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
